[rtl/assert_macros.svh]
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define AXSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("axsh assertion failed");

// next-cycle implication, masked while reset is asserted
`define AXSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("axsh assertion failed");

// next-cycle implication, also checked during reset
`define AXSH_ASSERT_ALWAYS(lbl, clk, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error("axsh assertion failed");

`endif

[rtl/axsh_pkg.sv]
// types, constants and mixing functions of the add-xor-shift 512-bit hash
package axsh_pkg;

	typedef logic [63:0] word_t;
	typedef word_t [7:0] lanes_t;
	typedef logic [1:0] kind_t;
	typedef logic [6:0] count_t;

	localparam kind_t KIND_ABSORB  = 2'd0;
	localparam kind_t KIND_FINISH  = 2'd1;
	localparam kind_t KIND_RESTART = 2'd2;

	localparam count_t BLOCK_BYTES = 7'd64;

	localparam word_t INIT_CONST [8] = '{
		64'hA640524A5B44F1FC, 64'hC535059705F0BB7E,
		64'hC8ED76CF6B6EA626, 64'h531D1E8E254EA59E,
		64'h8C0FE7F3E46E2A80, 64'h1C53F41FD1E3A7F8,
		64'h08D4DEAAA1C33335, 64'h4C592980FBE9B011
	};

	// shift per row: right on even rows, left on odd rows
	localparam int ROW_SHIFT [8] = '{9, 9, 23, 15, 14, 20, 17, 14};

	typedef struct packed {
		kind_t  kind;
		word_t  word_0;
		word_t  word_1;
		word_t  word_2;
		word_t  word_3;
		word_t  word_4;
		word_t  word_5;
		word_t  word_6;
		word_t  word_7;
		count_t byte_count;
	} item_t;

	typedef struct packed {
		word_t digest_0;
		word_t digest_1;
		word_t digest_2;
		word_t digest_3;
		word_t digest_4;
		word_t digest_5;
		word_t digest_6;
		word_t digest_7;
	} digest_t;

	function automatic word_t bswap64(word_t x);
		word_t r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = x[8*(7-i) +: 8];
		end
		return r;
	endfunction

	function automatic lanes_t init_lanes();
		lanes_t l;
		for (int i = 0; i < 8; i++) begin
			l[i] = bswap64(INIT_CONST[i]);
		end
		return l;
	endfunction

	// eight rows mixing an external block into the lanes
	function automatic lanes_t mix_block(lanes_t s, lanes_t v);
		logic [2:0] ia;
		logic [2:0] ib;
		logic [2:0] ic;
		logic [2:0] ik;
		word_t src;
		for (int k = 0; k < 8; k++) begin
			ik = 3'(k);
			ia = 3'(k + 4);
			ib = 3'(k + 5);
			ic = 3'(k + 7);
			s[ik] = s[ik] - v[ia];
			src = v[ic];
			if ((k % 2) == 0) begin
				s[ib] = s[ib] ^ (src >> ROW_SHIFT[k]);
			end else begin
				s[ib] = s[ib] ^ (src << ROW_SHIFT[k]);
			end
			s[ic] = s[ic] + v[ik];
		end
		return s;
	endfunction

	// eight rows mixing the lanes with themselves, updated in place
	function automatic lanes_t mix_self(lanes_t s);
		logic [2:0] ia;
		logic [2:0] ib;
		logic [2:0] ic;
		logic [2:0] ik;
		word_t src;
		for (int k = 0; k < 8; k++) begin
			ik = 3'(k);
			ia = 3'(k + 4);
			ib = 3'(k + 5);
			ic = 3'(k + 7);
			s[ik] = s[ik] - s[ia];
			src = s[ic];
			if ((k % 2) == 0) begin
				s[ib] = s[ib] ^ (src >> ROW_SHIFT[k]);
			end else begin
				s[ib] = s[ib] ^ (src << ROW_SHIFT[k]);
			end
			s[ic] = s[ic] + s[ik];
		end
		return s;
	endfunction

endpackage

[rtl/axsh_item_if.sv]
// valid/ready channel carrying input transactions
interface axsh_item_if
	import axsh_pkg::*;
();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/axsh_result_if.sv]
// valid/ready channel carrying digest transactions
interface axsh_result_if
	import axsh_pkg::*;
();
	logic    valid;
	logic    ready;
	digest_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/add_xor_shift_hash_512_core.sv]
// top level of the add-xor-shift 512-bit hash core
//
//   channel  role  payload                         transaction
//   item     sink  kind, word_0..7, byte_count     absorb / finish / restart
//   result   src   digest_0..7                     one per finish
//
// one transaction per cycle while item.ready stays high: input register, then a single pass
// of 16 mixing rows into the lane registers and the digest register.
// an item is held in the input register until it advances; its digest is then registered.
// item.ready drops only when a finish waits behind an unaccepted digest.
// reset loads the byte-swapped constants into the lanes and clears the counter.
module add_xor_shift_hash_512_core
	import axsh_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	axsh_item_if.sink     item,
	axsh_result_if.source result
);
	logic    valid_s1;
	kind_t   kind_s1;
	lanes_t  blk_s1;
	count_t  cnt_s1;
	lanes_t  lanes_q;
	word_t   total_q;
	logic    out_valid_q;
	digest_t out_data_q;
	lanes_t  lanes_next;
	word_t   total_next;
	logic    emit;
	logic    advance;
	lanes_t  blk_in;
	count_t  cnt_in;

	// zero bytes at and beyond the count, and clamp the count to BLOCK_BYTES
	always_comb begin
		blk_in = {item.data.word_7, item.data.word_6, item.data.word_5, item.data.word_4,
			item.data.word_3, item.data.word_2, item.data.word_1, item.data.word_0};
		for (int j = 0; j < 64; j++) begin
			if (7'(j) >= item.data.byte_count) begin
				blk_in[j / 8][8*(j % 8) +: 8] = 8'd0;
			end
		end
		cnt_in = (item.data.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : item.data.byte_count;
	end

	assign advance = !(valid_s1 && (kind_s1 == KIND_FINISH) && out_valid_q && !result.ready);
	assign item.ready = !valid_s1 || advance;

	axsh_mix u_mix (
		.kind       (kind_s1),
		.blk        (blk_s1),
		.cnt        (cnt_s1),
		.lanes      (lanes_q),
		.total      (total_q),
		.lanes_next (lanes_next),
		.total_next (total_next),
		.emit       (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1 <= item.data.kind;
			blk_s1 <= blk_in;
			cnt_s1 <= cnt_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= init_lanes();
			total_q <= '0;
		end else if (valid_s1 && advance) begin
			lanes_q <= lanes_next;
			total_q <= total_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && emit) begin
			out_data_q <= {lanes_next[0], lanes_next[1], lanes_next[2], lanes_next[3],
				lanes_next[4], lanes_next[5], lanes_next[6], lanes_next[7]};
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_data_q;
endmodule

[rtl/axsh_mix.sv]
// next-state logic: absorb, finish and restart applied to lanes and counter
module axsh_mix
	import axsh_pkg::*;
(
	input  kind_t  kind,
	input  lanes_t blk,
	input  count_t cnt,
	input  lanes_t lanes,
	input  word_t  total,
	output lanes_t lanes_next,
	output word_t  total_next,
	output logic   emit
);
	lanes_t total_blk;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			total_blk[i] = total;
		end
	end

	always_comb begin
		lanes_next = lanes;
		total_next = total;
		emit = 1'b0;
		unique case (kind)
			KIND_ABSORB: begin
				if (cnt != '0) begin
					total_next = total + {57'd0, cnt};
					lanes_next = mix_self(mix_block(lanes, blk));
				end
			end
			KIND_FINISH: begin
				emit = 1'b1;
				if (total != '0) begin
					lanes_next = mix_self(mix_block(lanes, total_blk));
				end
			end
			KIND_RESTART: begin
				lanes_next = init_lanes();
				total_next = '0;
			end
			default: begin
			end
		endcase
	end
endmodule

[rtl/axsh_checker.sv]
// port-level checks for the hash core and their bind
`include "assert_macros.svh"

module axsh_checker
	import axsh_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input kind_t   item_kind,
	input logic    result_valid,
	input logic    result_ready,
	input digest_t result_data
);
	`AXSH_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n, !result_valid)
	`AXSH_ASSERT_NEXT(a_stall_holds, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(result_data))
	`AXSH_ASSERT_NOW(a_result_from_finish, clk, arst_n, $rose(result_valid),
		$past(item_valid && item_ready && (item_kind == KIND_FINISH), 2))
	`AXSH_ASSERT_NOW(a_ready_only_on_stall, clk, arst_n, !item_ready,
		result_valid && !result_ready)
endmodule

bind add_xor_shift_hash_512_core axsh_checker u_axsh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_kind    (item.data.kind),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

[sim/add_xor_shift_hash_512_core_test.sv]
// self-checking testbench for the add-xor-shift 512-bit hash core
`timescale 1ns / 1ps

module add_xor_shift_hash_512_core_test;
	import axsh_pkg::*;

	typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

	localparam kind_t KIND_UNUSED = 2'd3;

	localparam word_t IV_WORDS [8] = '{
		64'hA640524A5B44F1FC, 64'hC535059705F0BB7E,
		64'hC8ED76CF6B6EA626, 64'h531D1E8E254EA59E,
		64'h8C0FE7F3E46E2A80, 64'h1C53F41FD1E3A7F8,
		64'h08D4DEAAA1C33335, 64'h4C592980FBE9B011
	};
	localparam int LANE_SHIFT [8] = '{9, 9, 23, 15, 14, 20, 17, 14};

	logic clk;
	logic arst_n;

	axsh_item_if   item_ch();
	axsh_result_if digest_ch();

	lanes_t  hash_lanes;
	word_t   bytes_absorbed;
	digest_t expected_digests [$];
	int      mismatch_count = 0;
	bit      tx_steady = 1'b0;
	bit      rx_steady = 1'b0;
	int      rx_hold_cycles = 0;

	add_xor_shift_hash_512_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (digest_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#3_000_000;
		$display("add_xor_shift_hash_512_core_test: FAIL");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic word_t reverse_bytes(word_t x);
		word_t r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r = (r << 8) | (x & 64'hFF);
			x = x >> 8;
		end
		return r;
	endfunction

	// in place: the lanes are mixed with themselves and v is unused
	function automatic lanes_t mix_rows(lanes_t s, lanes_t v, bit in_place);
		word_t sub;
		word_t src;
		word_t add;
		for (int k = 0; k < 8; k++) begin
			sub = in_place ? s[(k + 4) % 8] : v[(k + 4) % 8];
			s[k] = s[k] - sub;
			src = in_place ? s[(k + 7) % 8] : v[(k + 7) % 8];
			if (k % 2 == 0) begin
				s[(k + 5) % 8] = s[(k + 5) % 8] ^ (src >> LANE_SHIFT[k]);
			end else begin
				s[(k + 5) % 8] = s[(k + 5) % 8] ^ (src << LANE_SHIFT[k]);
			end
			add = in_place ? s[k] : v[k];
			s[(k + 7) % 8] = s[(k + 7) % 8] + add;
		end
		return s;
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < 8; i++) begin
			hash_lanes[i] = reverse_bytes(IV_WORDS[i]);
		end
		bytes_absorbed = '0;
	endtask

	task automatic absorb_block(lanes_t blk);
		hash_lanes = mix_rows(hash_lanes, blk, 1'b0);
		hash_lanes = mix_rows(hash_lanes, hash_lanes, 1'b1);
	endtask

	task automatic advance_hash(item_t it);
		lanes_t  blk;
		int      cnt;
		int      n;
		word_t   mask;
		digest_t d;
		case (it.kind)
			KIND_ABSORB: begin
				cnt = (it.byte_count > BLOCK_BYTES) ? int'(BLOCK_BYTES) : int'(it.byte_count);
				if (cnt != 0) begin
					blk = {it.word_7, it.word_6, it.word_5, it.word_4,
						it.word_3, it.word_2, it.word_1, it.word_0};
					for (int i = 0; i < 8; i++) begin
						n = cnt - 8 * i;
						if (n >= 8) begin
							mask = '1;
						end else if (n <= 0) begin
							mask = '0;
						end else begin
							mask = (64'd1 << (8 * n)) - 64'd1;
						end
						blk[i] = blk[i] & mask;
					end
					bytes_absorbed = bytes_absorbed + word_t'(cnt);
					absorb_block(blk);
				end
			end
			KIND_FINISH: begin
				if (bytes_absorbed != '0) begin
					absorb_block({8{bytes_absorbed}});
				end
				d = {hash_lanes[0], hash_lanes[1], hash_lanes[2], hash_lanes[3],
					hash_lanes[4], hash_lanes[5], hash_lanes[6], hash_lanes[7]};
				expected_digests.insert(expected_digests.size(), d);
			end
			KIND_RESTART: begin
				restart_hash();
			end
			default: begin
			end
		endcase
	endtask

	function automatic word_t fill_word(fill_t f);
		case (f)
			FILL_ONES:  return '1;
			FILL_ZEROS: return '0;
			default:    return {$urandom, $urandom};
		endcase
	endfunction

	function automatic item_t build_item(kind_t k, count_t n, fill_t f);
		item_t it;
		it.kind = k;
		it.word_0 = fill_word(f);
		it.word_1 = fill_word(f);
		it.word_2 = fill_word(f);
		it.word_3 = fill_word(f);
		it.word_4 = fill_word(f);
		it.word_5 = fill_word(f);
		it.word_6 = fill_word(f);
		it.word_7 = fill_word(f);
		it.byte_count = n;
		return it;
	endfunction

	task automatic push_item(item_t it);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		advance_hash(it);
	endtask

	task automatic push(kind_t k, count_t n, fill_t f);
		push_item(build_item(k, n, f));
	endtask

	task automatic check_digest(digest_t got);
		digest_t     want;
		word_t [7:0] g;
		word_t [7:0] w;
		if (expected_digests.size() == 0) begin
			report_mismatch("digest transaction with no finish pending");
			return;
		end
		want = expected_digests.pop_front();
		g = got;
		w = want;
		for (int i = 0; i < 8; i++) begin
			if (g[7 - i] !== w[7 - i]) begin
				report_mismatch($sformatf("digest_%0d got %h expected %h",
					i, g[7 - i], w[7 - i]));
			end
		end
	endtask

	initial begin
		int stall;
		digest_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				digest_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			digest_ch.ready <= 1'b1;
			@(posedge clk);
			while (!digest_ch.valid) @(posedge clk);
			check_digest(digest_ch.data);
		end
	end

	task automatic test_empty_finish();
		push(KIND_FINISH, 7'd0, FILL_RANDOM);
		push(KIND_UNUSED, 7'd127, FILL_ONES);
		push(KIND_FINISH, 7'd64, FILL_ZEROS);
	endtask

	task automatic test_partial_blocks();
		push(KIND_ABSORB, 7'd0, FILL_ONES);
		push(KIND_ABSORB, 7'd1, FILL_RANDOM);
		push(KIND_ABSORB, 7'd7, FILL_RANDOM);
		push(KIND_ABSORB, 7'd8, FILL_RANDOM);
		push(KIND_ABSORB, 7'd9, FILL_RANDOM);
		push(KIND_ABSORB, 7'd63, FILL_RANDOM);
		push(KIND_ABSORB, 7'd64, FILL_ONES);
		push(KIND_FINISH, 7'd0, FILL_RANDOM);
	endtask

	task automatic test_oversized_counts();
		push(KIND_ABSORB, 7'd65, FILL_ONES);
		push(KIND_ABSORB, 7'd127, FILL_ONES);
		push(KIND_ABSORB, 7'd64, FILL_ZEROS);
		push(KIND_FINISH, 7'd0, FILL_ZEROS);
		push(KIND_FINISH, 7'd0, FILL_ONES);
	endtask

	task automatic test_restart();
		push(KIND_RESTART, 7'd0, FILL_RANDOM);
		push(KIND_FINISH, 7'd0, FILL_RANDOM);
		push(KIND_ABSORB, 7'd32, FILL_RANDOM);
		push(KIND_RESTART, 7'd127, FILL_ONES);
		push(KIND_FINISH, 7'd0, FILL_RANDOM);
	endtask

	// receiver holds off while finishes arrive back to back
	task automatic test_backpressure();
		tx_steady = 1'b1;
		rx_hold_cycles = 120;
		push(KIND_FINISH, 7'd0, FILL_RANDOM);
		push(KIND_ABSORB, 7'd40, FILL_RANDOM);
		repeat (3) push(KIND_FINISH, 7'd0, FILL_RANDOM);
		push(KIND_ABSORB, 7'd64, FILL_RANDOM);
		repeat (6) push(KIND_FINISH, 7'd0, FILL_RANDOM);
		tx_steady = 1'b0;
	endtask

	task automatic test_random_stream(int count);
		int     pick;
		int     sel;
		count_t n;
		fill_t  f;
		for (int i = 0; i < count; i++) begin
			tx_steady = (i % 100) >= 85;
			rx_steady = (i % 130) >= 110;
			pick = $urandom_range(0, 99);
			sel = $urandom_range(0, 99);
			f = (sel < 90) ? FILL_RANDOM : (sel < 95) ? FILL_ONES : FILL_ZEROS;
			if (pick < 78) begin
				sel = $urandom_range(0, 99);
				if (sel < 80) begin
					n = count_t'($urandom_range(1, 64));
				end else if (sel < 90) begin
					n = BLOCK_BYTES;
				end else if (sel < 95) begin
					n = '0;
				end else begin
					n = count_t'($urandom_range(65, 127));
				end
				push(KIND_ABSORB, n, f);
			end else if (pick < 92) begin
				push(KIND_FINISH, count_t'($urandom_range(0, 127)), f);
			end else if (pick < 97) begin
				push(KIND_RESTART, count_t'($urandom_range(0, 127)), f);
			end else begin
				push(KIND_UNUSED, count_t'($urandom_range(0, 127)), f);
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		int waited;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		arst_n = 1'b0;
		restart_hash();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_finish();
		test_partial_blocks();
		test_oversized_counts();
		test_restart();
		test_backpressure();
		test_random_stream(480);

		item_ch.valid <= 1'b0;
		waited = 0;
		while (expected_digests.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_digests.size() != 0) begin
			report_mismatch($sformatf("%0d digests never arrived", expected_digests.size()));
		end
		if (mismatch_count == 0) begin
			$display("add_xor_shift_hash_512_core_test: PASS");
		end else begin
			$display("add_xor_shift_hash_512_core_test: FAIL");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/axsh_pkg.sv
rtl/axsh_item_if.sv
rtl/axsh_result_if.sv
rtl/axsh_mix.sv
rtl/add_xor_shift_hash_512_core.sv
rtl/axsh_checker.sv
sim/add_xor_shift_hash_512_core_test.sv
